// ===== rtl/stcf_pkg.sv =====
// stcf_pkg: shared types, widths and helpers for the STCF job dispatcher.
// Used by stcf_table_ram, stcf_scan and stcf_job_dispatcher. No dependencies.
`default_nettype none

package stcf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int LEN_W    = 16;
  localparam int CLK_W    = 24;
  localparam int JIDX_W   = 4;

  localparam logic [LEN_W-1:0] SLICE_RESET = LEN_W'(10);

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_IDLE_TICK = 2'd2,
    STAT_DONE      = 2'd3
  } status_t;

  typedef struct packed {
    logic             func;
    logic [LEN_W-1:0] arrival_time;
    logic [LEN_W-1:0] job_length;
  } job_in_t;

  typedef struct packed {
    status_t           status;
    logic [CLK_W-1:0]  start_time;
    logic [JIDX_W-1:0] job_index;
    logic [LEN_W-1:0]  ran_for;
    logic              job_finished;
    logic [CLK_W-1:0]  response_time;
    logic [CLK_W-1:0]  wait_time;
    logic [CLK_W-1:0]  turnaround_time;
  } job_out_t;

  // One job table row; all fields live in a single memory word.
  typedef struct packed {
    logic [LEN_W-1:0] arrival;
    logic [LEN_W-1:0] remaining;
    logic [CLK_W-1:0] response;
    logic [CLK_W-1:0] wait_acc;
    logic [CLK_W-1:0] last_end;
    logic             started;
  } entry_t;

  // Scan control from the sequencer.
  typedef struct packed {
    logic             start;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // Scan outcome back to the sequencer.
  typedef struct packed {
    logic             any_left;
    logic             have_pick;
    logic [IDX_W-1:0] best_idx;
    entry_t           best;
  } scan_res_t;

  function automatic logic [CLK_W-1:0] add_sat(input logic [CLK_W-1:0] a,
                                               input logic [CLK_W-1:0] b);
    logic [CLK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CLK_W] ? {CLK_W{1'b1}} : s[CLK_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stcf_table_ram.sv =====
// stcf_table_ram: job table, one row per job, one write and one read port.
// Read data is registered and appears the cycle after raddr. Depends on stcf_pkg.
`default_nettype none

module stcf_table_ram
  import stcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output entry_t                rdata
);

  entry_t mem [MAX_JOBS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/stcf_scan.sv =====
// stcf_scan: walks the table read stream, tracks pending work and the
// shortest arrived job. Depends on stcf_pkg.
`default_nettype none

module stcf_scan
  import stcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scan_ctl_t        ctl,
  input  wire entry_t           rdata,
  input  wire logic [CLK_W-1:0] cur_clock,
  output scan_res_t             res
);

  logic             any_left;
  logic             have_pick;
  logic             stopped;
  logic [IDX_W-1:0] best_idx;
  entry_t           best;

  logic not_arrived;
  logic better;

  assign not_arrived = CLK_W'(rdata.arrival) > cur_clock;
  assign better      = (rdata.remaining != '0) &&
                       (!have_pick || (rdata.remaining < best.remaining));

  always_ff @(posedge clk) begin
    if (rst) begin
      any_left  <= 1'b0;
      have_pick <= 1'b0;
      stopped   <= 1'b0;
    end else if (ctl.start) begin
      any_left  <= 1'b0;
      have_pick <= 1'b0;
      stopped   <= 1'b0;
    end else if (ctl.hit) begin
      if (rdata.remaining != '0) begin
        any_left <= 1'b1;
      end
      // scan for a pick ends at the first job still in the future
      if (!stopped) begin
        if (not_arrived) begin
          stopped <= 1'b1;
        end else if (better) begin
          have_pick <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit && !ctl.start && !stopped && !not_arrived && better) begin
      best     <= rdata;
      best_idx <= ctl.idx;
    end
  end

  assign res.any_left  = any_left;
  assign res.have_pick = have_pick;
  assign res.best_idx  = best_idx;
  assign res.best      = best;

endmodule

`default_nettype wire

// ===== rtl/stcf_job_dispatcher.sv =====
// stcf_job_dispatcher: top level of the shortest-remaining-time dispatcher.
// Depends on stcf_pkg, stcf_table_ram, stcf_scan.
`default_nettype none

//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+------------------------------
//  cmd     | in  | cmd_valid / cmd_stall     | job_in_t: func, arrival, length
//  rsp     | out | rsp_valid / rsp_stall     | job_out_t: one result per cmd
//  slice   | in  | slice_valid / slice_ready | time_slice register, 16 bit
//
//  A load passes through S_LOAD and S_EMIT. A dispatch reads the table in S_SCAN:
//  one table row is read per cycle over the single read port of the table
//  memory, then the chosen row, held by the scan, is updated in S_CALC and
//  written back in S_WRITE before S_EMIT. An empty table or an idle tick
//  goes from S_SCAN straight to S_EMIT.
//  Reset (rst, synchronous) empties the table, zeroes the clock and sets the
//  slice to 10. The table memory itself is not cleared; only loaded rows are read.
//  rsp has an output register: a held result does not block the next cmd,
//  only the emission of the following result.

module stcf_job_dispatcher
  import stcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_stall,
  input  wire job_in_t          cmd,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output job_out_t              rsp,
  input  wire logic             slice_valid,
  output logic                  slice_ready,
  input  wire logic [LEN_W-1:0] slice_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_CALC,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] job_count;
  logic [CLK_W-1:0] current_clock;
  logic [LEN_W-1:0] time_slice;
  job_in_t          cmd_reg;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_pend_idx;
  job_out_t         hold;

  // registered by S_CALC
  logic [LEN_W-1:0] run;
  logic [CLK_W-1:0] end_time;
  logic [CLK_W-1:0] first_resp;
  logic [CLK_W-1:0] gap;

  // memory and scan hookup
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;
  scan_ctl_t        sctl;
  scan_res_t        sres;

  logic cmd_acc;
  logic rsp_free;
  logic rd_more;

  // S_CALC datapath
  logic [LEN_W-1:0] slice_eff;
  logic [LEN_W-1:0] run_c;
  logic [CLK_W-1:0] end_c;
  logic [CLK_W-1:0] resp_c;
  logic [CLK_W-1:0] gap_c;

  // S_WRITE datapath
  entry_t           upd;
  logic             fin;

  assign cmd_stall   = (state != S_IDLE);
  assign cmd_acc     = cmd_valid && !cmd_stall;
  assign rsp_free    = !rsp_valid || !rsp_stall;
  assign slice_ready = 1'b1;
  assign rd_more     = (rd_idx < job_count);

  always_comb begin
    slice_eff = (time_slice == '0) ? LEN_W'(1) : time_slice;
    run_c     = (sres.best.remaining < slice_eff) ? sres.best.remaining : slice_eff;
    end_c     = add_sat(current_clock, CLK_W'(run_c));
    resp_c    = current_clock - CLK_W'(sres.best.arrival);
    gap_c     = (current_clock >= sres.best.last_end) ?
                (current_clock - sres.best.last_end) : '0;
  end

  always_comb begin
    upd           = sres.best;
    upd.remaining = sres.best.remaining - run;
    upd.last_end  = end_time;
    upd.started   = 1'b1;
    if (sres.best.started) begin
      upd.wait_acc = add_sat(sres.best.wait_acc, gap);
    end else begin
      upd.response = first_resp;
      upd.wait_acc = first_resp;
    end
    fin = (upd.remaining == '0);
  end

  // table write: append on load, write-back on dispatch
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sres.best_idx;
    mem_wdata = upd;
    if (state == S_LOAD) begin
      mem_we             = (job_count != CNT_W'(MAX_JOBS));
      mem_waddr          = job_count[IDX_W-1:0];
      mem_wdata          = '0;
      mem_wdata.arrival  = cmd_reg.arrival_time;
      mem_wdata.remaining = cmd_reg.job_length;
    end else if (state == S_WRITE) begin
      mem_we = 1'b1;
    end
  end

  assign sctl.start = cmd_acc;
  assign sctl.hit   = rd_pend;
  assign sctl.idx   = rd_pend_idx;

  stcf_table_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  stcf_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .rdata     (mem_rdata),
    .cur_clock (current_clock),
    .res       (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      job_count     <= '0;
      current_clock <= '0;
      time_slice    <= SLICE_RESET;
      rd_idx        <= '0;
      rd_pend       <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (slice_valid && slice_ready) begin
        time_slice <= slice_data;
      end
      // new word goes out when the output register is free
      if (state == S_EMIT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            cmd_reg <= cmd;
            hold    <= '0;
            rd_idx  <= '0;
            rd_pend <= 1'b0;
            if (cmd.func == FUNC_LOAD) begin
              state <= S_LOAD;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_LOAD: begin
          if (job_count == CNT_W'(MAX_JOBS)) begin
            hold.status <= STAT_FULL;
          end else begin
            hold.status    <= STAT_OK;
            hold.job_index <= JIDX_W'(job_count[IDX_W-1:0]);
            job_count      <= job_count + CNT_W'(1);
          end
          state <= S_EMIT;
        end

        S_SCAN: begin
          if (rd_more) begin
            rd_idx      <= rd_idx + CNT_W'(1);
            rd_pend     <= 1'b1;
            rd_pend_idx <= rd_idx[IDX_W-1:0];
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              if (!sres.any_left) begin
                hold.status <= STAT_DONE;
                state       <= S_EMIT;
              end else if (!sres.have_pick) begin
                hold.status     <= STAT_IDLE_TICK;
                hold.start_time <= current_clock;
                current_clock   <= add_sat(current_clock, CLK_W'(1));
                state           <= S_EMIT;
              end else begin
                state <= S_CALC;
              end
            end
          end
        end

        S_CALC: begin
          run        <= run_c;
          end_time   <= end_c;
          first_resp <= resp_c;
          gap        <= gap_c;
          state      <= S_WRITE;
        end

        S_WRITE: begin
          hold.status        <= STAT_OK;
          hold.start_time    <= current_clock;
          hold.job_index     <= JIDX_W'(sres.best_idx);
          hold.ran_for       <= run;
          hold.job_finished  <= fin;
          hold.response_time <= upd.response;
          hold.wait_time     <= upd.wait_acc;
          hold.turnaround_time <= fin ? (end_time - CLK_W'(sres.best.arrival)) : '0;
          current_clock      <= end_time;
          state              <= S_EMIT;
        end

        S_EMIT: begin
          if (rsp_free) begin
            rsp   <= hold;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= CNT_W'(MAX_JOBS))
    else $error("job_count beyond table depth");

  // the clock only moves forward between resets
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> current_clock >= $past(current_clock))
    else $error("dispatch clock went backward");

  // a run is only computed for a loaded job with work left
  a_pick_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> (sres.best.remaining != '0) &&
                        (CNT_W'(sres.best_idx) < job_count))
    else $error("picked job not runnable");

  // a write-back always consumes at least one tick of work
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> run != '0)
    else $error("zero-length run");

endmodule

`default_nettype wire

// ===== tb/stcf_job_dispatcher_check.sv =====
// stcf_job_dispatcher_check: watches the cmd, rsp and slice channels of the dispatcher,
// predicts every result word and compares it field by field. Depends on stcf_pkg.
`timescale 1ns / 100ps

module stcf_job_dispatcher_check
  import stcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire logic             cmd_stall,
  input  wire job_in_t          cmd,
  input  wire logic             rsp_valid,
  input  wire logic             rsp_stall,
  input  wire job_out_t         rsp,
  input  wire logic             slice_valid,
  input  wire logic             slice_ready,
  input  wire logic [LEN_W-1:0] slice_data,
  output int                    mismatches,
  output int                    words_pending
);

  localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};

  // predicted scheduler state
  logic [LEN_W-1:0] arrival_tab  [MAX_JOBS];
  logic [LEN_W-1:0] remain_tab   [MAX_JOBS];
  logic [CLK_W-1:0] response_tab [MAX_JOBS];
  logic [CLK_W-1:0] wait_tab     [MAX_JOBS];
  logic [CLK_W-1:0] last_end_tab [MAX_JOBS];
  logic             started_tab  [MAX_JOBS];
  int               jobs_loaded;
  logic [CLK_W-1:0] sched_clock;
  logic [LEN_W-1:0] slice_reg;

  job_out_t job_result_q[$];
  int       result_seq;

  function automatic logic [CLK_W-1:0] clock_add(input logic [CLK_W-1:0] a,
                                                 input logic [CLK_W-1:0] b);
    logic [CLK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CLK_W] ? CLOCK_MAX : s[CLK_W-1:0];
  endfunction

  function automatic void reset_schedule();
    for (int i = 0; i < MAX_JOBS; i++) begin
      arrival_tab[i]  = '0;
      remain_tab[i]   = '0;
      response_tab[i] = '0;
      wait_tab[i]     = '0;
      last_end_tab[i] = '0;
      started_tab[i]  = 1'b0;
    end
    jobs_loaded = 0;
    sched_clock = '0;
    slice_reg   = SLICE_RESET;
  endfunction

  // Advances the predicted table by one word and returns the result it causes.
  function automatic job_out_t predict_job_result(input job_in_t w);
    job_out_t         r;
    int               pick;
    bit               any_left;
    logic [LEN_W-1:0] slice;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] run;
    logic [CLK_W-1:0] start;
    logic [CLK_W-1:0] fin;
    logic [CLK_W-1:0] gap;
    r = '0;
    if (w.func == FUNC_LOAD) begin
      if (jobs_loaded >= MAX_JOBS) begin
        r.status = STAT_FULL;
        return r;
      end
      arrival_tab[jobs_loaded]  = w.arrival_time;
      remain_tab[jobs_loaded]   = w.job_length;
      response_tab[jobs_loaded] = '0;
      wait_tab[jobs_loaded]     = '0;
      last_end_tab[jobs_loaded] = '0;
      started_tab[jobs_loaded]  = 1'b0;
      r.status    = STAT_OK;
      r.job_index = JIDX_W'(jobs_loaded);
      jobs_loaded++;
      return r;
    end
    any_left = 1'b0;
    for (int i = 0; i < jobs_loaded; i++)
      if (remain_tab[i] != '0) any_left = 1'b1;
    if (!any_left) begin
      r.status = STAT_DONE;
      return r;
    end
    // scan stops at the first job that has not arrived yet
    pick = -1;
    for (int i = 0; i < jobs_loaded; i++) begin
      if (CLK_W'(arrival_tab[i]) > sched_clock) break;
      if (remain_tab[i] != '0 && (pick < 0 || remain_tab[i] < remain_tab[pick]))
        pick = i;
    end
    if (pick < 0) begin
      r.status     = STAT_IDLE_TICK;
      r.start_time = sched_clock;
      sched_clock  = clock_add(sched_clock, CLK_W'(1));
      return r;
    end
    slice = (slice_reg == '0) ? LEN_W'(1) : slice_reg;
    rem   = remain_tab[pick];
    run   = (rem < slice) ? rem : slice;
    start = sched_clock;
    if (!started_tab[pick]) begin
      response_tab[pick] = start - CLK_W'(arrival_tab[pick]);
      wait_tab[pick]     = response_tab[pick];
      started_tab[pick]  = 1'b1;
    end else begin
      gap = (start >= last_end_tab[pick]) ? start - last_end_tab[pick] : '0;
      wait_tab[pick] = clock_add(wait_tab[pick], gap);
    end
    fin                = clock_add(start, CLK_W'(run));
    sched_clock        = fin;
    remain_tab[pick]   = rem - run;
    last_end_tab[pick] = fin;
    r.status        = STAT_OK;
    r.start_time    = start;
    r.job_index     = JIDX_W'(pick);
    r.ran_for       = run;
    r.job_finished  = (remain_tab[pick] == '0);
    r.response_time = response_tab[pick];
    r.wait_time     = wait_tab[pick];
    r.turnaround_time = (remain_tab[pick] == '0) ? fin - CLK_W'(arrival_tab[pick]) : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                result_seq, name, got, want));
  endtask

  task automatic compare_result(input job_out_t got, input job_out_t want);
    check_field("status",          32'(got.status),          32'(want.status));
    check_field("start_time",      32'(got.start_time),      32'(want.start_time));
    check_field("job_index",       32'(got.job_index),       32'(want.job_index));
    check_field("ran_for",         32'(got.ran_for),         32'(want.ran_for));
    check_field("job_finished",    32'(got.job_finished),    32'(want.job_finished));
    check_field("response_time",   32'(got.response_time),   32'(want.response_time));
    check_field("wait_time",       32'(got.wait_time),       32'(want.wait_time));
    check_field("turnaround_time", 32'(got.turnaround_time), 32'(want.turnaround_time));
  endtask

  initial begin
    reset_schedule();
    result_seq = 0;
  end

  always @(posedge clk) begin
    job_out_t want;
    if (rst) begin
      reset_schedule();
      job_result_q.delete();
    end else begin
      if (slice_valid && slice_ready) slice_reg = slice_data;
      if (cmd_valid && !cmd_stall) job_result_q.push_back(predict_job_result(cmd));
      if (rsp_valid && !rsp_stall) begin
        if (job_result_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_seq));
        end else begin
          want = job_result_q.pop_front();
          compare_result(rsp, want);
        end
        result_seq++;
      end
    end
    words_pending <= job_result_q.size();
  end

endmodule

// ===== tb/stcf_job_dispatcher_test.sv =====
// stcf_job_dispatcher_test: stimulus and verdict for the STCF job dispatcher.
// Depends on stcf_pkg, stcf_job_dispatcher and stcf_job_dispatcher_check.
`timescale 1ns / 100ps

module stcf_job_dispatcher_test;
  import stcf_pkg::*;

  // watchdog bound on the whole run, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int          PHASE_WORDS   = 320;
  localparam int          SETTLE_CYCLES = 30;   // idle time after the last result comes back
  localparam int          HOLD_CYCLES   = 400;  // long rsp hold-off, fills the block

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  job_in_t          cmd = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  job_out_t         rsp;
  logic             slice_valid = 1'b0;
  logic             slice_ready;
  logic [LEN_W-1:0] slice_data = '0;

  int          mismatch_total;
  int          words_pending;
  int unsigned cycle_count = 0;
  int          tx_idle_pct = 0;   // chance the sender skips a cycle
  int          rx_idle_pct = 0;   // chance the receiver stalls a cycle
  int          phase_no = -1;     // -1: directed part
  int          loads_sent = 0;
  logic        hold_rsp = 1'b0;

  always #1 clk = ~clk;

  stcf_job_dispatcher dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .slice_valid (slice_valid),
    .slice_ready (slice_ready),
    .slice_data  (slice_data)
  );

  stcf_job_dispatcher_check check (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .slice_valid   (slice_valid),
    .slice_ready   (slice_ready),
    .slice_data    (slice_data),
    .mismatches    (mismatch_total),
    .words_pending (words_pending)
  );

  // Watchdog: any hang in a handshake loop ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls per phase, plus the long hold-off below.
  always @(posedge clk)
    rsp_stall <= hold_rsp || (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct);

  // One long hold-off early in the second random phase. The sender keeps
  // offering words meanwhile, so the output register and the next result
  // held in S_EMIT fill up and cmd_stall has to rise.
  initial begin
    wait (phase_no == 1);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // Offers one word and returns at the edge that accepts it. Valid stays high
  // into the next call unless the sender idles, so it is never lowered and
  // raised in the same step.
  task automatic send_word(input job_in_t w);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    if (w.func == FUNC_LOAD) loads_sent++;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic load_job(input logic [LEN_W-1:0] arrival, input logic [LEN_W-1:0] length);
    send_word(job_in_t'{func: FUNC_LOAD, arrival_time: arrival, job_length: length});
  endtask

  // Dispatch ignores the other fields; fill them with noise anyway.
  task automatic dispatch_once();
    send_word(job_in_t'{func: FUNC_DISPATCH, arrival_time: LEN_W'($urandom()),
                        job_length: LEN_W'($urandom())});
  endtask

  // Stops offering and waits until every predicted result has come back,
  // then lets the block settle. The extra edge first makes sure the word
  // accepted last has been counted by the checker.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Slice register is only written with the block idle.
  task automatic set_slice(input logic [LEN_W-1:0] value);
    drain_results();
    slice_valid <= 1'b1;
    slice_data  <= value;
    @(posedge clk);
    while (!slice_ready) @(posedge clk);
    slice_valid <= 1'b0;
  endtask

  // Random word: mostly dispatches, a few loads. Loads that still fit the
  // table get arrivals the clock will reach and mostly short lengths, so jobs
  // finish and get preempted; the last slot gets the latest arrival.
  function automatic job_in_t random_job_word();
    job_in_t w;
    w.func         = ($urandom_range(0, 99) < 3) ? FUNC_LOAD : FUNC_DISPATCH;
    w.arrival_time = LEN_W'($urandom());
    w.job_length   = LEN_W'($urandom());
    if (w.func == FUNC_LOAD && loads_sent < MAX_JOBS) begin
      if (loads_sent == MAX_JOBS - 1) begin
        w.arrival_time = {LEN_W{1'b1}};
      end else begin
        case ($urandom_range(0, 9))
          0:       w.arrival_time = '0;
          1:       w.arrival_time = LEN_W'($urandom());
          default: w.arrival_time = LEN_W'($urandom_range(0, 4000));
        endcase
      end
      case ($urandom_range(0, 9))
        0:       w.job_length = '0;
        1:       w.job_length = {LEN_W{1'b1}};
        2, 3:    w.job_length = LEN_W'($urandom());
        default: w.job_length = LEN_W'($urandom_range(1, 400));
      endcase
    end
    return w;
  endfunction

  initial begin
    logic [LEN_W-1:0] phase_slice;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, slice still at its reset value of 10 ----
    dispatch_once();             // empty table: all done
    load_job(16'd0, 16'd0);      // zero-length job
    dispatch_once();             // only a finished job loaded: all done
    load_job(16'd3, 16'd25);
    dispatch_once();             // nothing arrived: idle ticks 0..2
    dispatch_once();
    dispatch_once();
    dispatch_once();             // job 1 runs a full slice
    load_job(16'd5, 16'd4);
    dispatch_once();             // job 2: short first run, still records response
    load_job(16'd0, 16'd15);     // ties with job 1's remaining 15
    dispatch_once();             // tie goes to the earlier row
    load_job(16'd0, 16'hFFFF);   // longest job
    dispatch_once();
    dispatch_once();
    set_slice(16'd0);            // zero slice acts as one
    dispatch_once();
    dispatch_once();
    dispatch_once();
    set_slice(16'hFFFF);         // widest slice: jobs run to completion
    dispatch_once();
    dispatch_once();
    dispatch_once();

    // ---- random phases: sender/receiver idle mix changes every two ----
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       phase_slice = LEN_W'($urandom_range(2, 40));
        1:       phase_slice = 16'd1;
        2:       phase_slice = 16'hFFFF;
        3:       phase_slice = LEN_W'($urandom_range(1, 65535));
        4:       phase_slice = 16'd0;
        default: phase_slice = SLICE_RESET;
      endcase
      set_slice(phase_slice);
      if (p < 2) begin
        tx_idle_pct = 34;
        rx_idle_pct = 73;
      end else if (p < 4) begin
        tx_idle_pct = 73;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      phase_no = p;
      repeat (PHASE_WORDS) send_word(random_job_word());
    end

    drain_results();
    if (mismatch_total == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
